// ===== rtl/sq8_pkg.sv =====
// Package for the eight-node serendipity quadrilateral shape evaluator.
// Holds fixed-point widths, derivative codes, control structs and the term decode table.
// No dependencies.
package sq8_pkg;

    localparam int COORD_FRAC_BITS = 14;
    localparam int COORD_W         = 16;
    localparam int FACT_W          = ((COORD_FRAC_BITS > 17) ? COORD_FRAC_BITS : 17) + 2;
    localparam int PROD_W          = 2 * FACT_W;
    localparam int RND_W           = PROD_W - COORD_FRAC_BITS + 1;
    localparam int VAL_W           = RND_W + FACT_W + 1;
    localparam int SH_W            = $clog2(COORD_FRAC_BITS + 3);
    localparam int OUT_W           = 18;

    localparam int IN_TDATA_W  = 2 * COORD_W;
    localparam int IN_TUSER_W  = 7;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 1;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [2:0] {
        D_VAL,
        D_DXI,
        D_DETA,
        D_DXI2,
        D_DETA2,
        D_DXIDETA
    } t_deriv;

    typedef enum logic [1:0] {
        NF_ONE,
        NF_TWO,
        NF_THREE
    } t_nf;

    typedef struct packed {
        logic signed [1:0] k0;
        logic signed [2:0] kx;
        logic signed [2:0] ky;
    } t_lin;

    typedef struct packed {
        logic       zero;
        logic       neg;
        logic [1:0] cs;
        t_nf        nf;
        t_lin       fa;
        t_lin       fb;
        t_lin       fc;
    } t_term;

    typedef struct packed {
        logic       zero;
        logic       inv;
        logic       neg;
        logic [1:0] cs;
        t_nf        nf;
    } t_ctl;

    function automatic t_lin lin(input int k0, input int kx, input int ky);
        t_lin l;
        l.k0 = 2'(k0);
        l.kx = 3'(kx);
        l.ky = 3'(ky);
        return l;
    endfunction

    function automatic t_term tm(input logic neg, input int cs, input t_nf nf,
                                 input t_lin fa, input t_lin fb, input t_lin fc);
        t_term t;
        t.zero = 1'b0;
        t.neg  = neg;
        t.cs   = 2'(cs);
        t.nf   = nf;
        t.fa   = fa;
        t.fb   = fb;
        t.fc   = fc;
        return t;
    endfunction

    function automatic t_term decode(input logic [2:0] node, input logic [2:0] dsel);
        t_term  t;
        t_lin   z;
        t_deriv d;
        z = lin(0, 0, 0);
        d = t_deriv'(dsel);
        t = tm(1'b0, 0, NF_ONE, z, z, z);
        t.zero = 1'b1;
        case (node)
            3'd0: begin
                case (d)
                    D_VAL:     t = tm(1'b1, 2, NF_THREE, lin(1,-1,0), lin(1,0,-1), lin(1,1,1));
                    D_DXI:     t = tm(1'b1, 2, NF_TWO, lin(-1,0,1), lin(0,2,1), z);
                    D_DETA:    t = tm(1'b1, 2, NF_TWO, lin(-1,1,0), lin(0,1,2), z);
                    D_DXI2:    t = tm(1'b0, 1, NF_ONE, lin(1,0,-1), z, z);
                    D_DETA2:   t = tm(1'b0, 1, NF_ONE, lin(1,-1,0), z, z);
                    D_DXIDETA: t = tm(1'b0, 2, NF_ONE, lin(1,-2,-2), z, z);
                    default: ;
                endcase
            end
            3'd1: begin
                case (d)
                    D_VAL:     t = tm(1'b1, 2, NF_THREE, lin(1,1,0), lin(1,0,-1), lin(1,-1,1));
                    D_DXI:     t = tm(1'b0, 2, NF_TWO, lin(-1,0,1), lin(0,-2,1), z);
                    D_DETA:    t = tm(1'b0, 2, NF_TWO, lin(1,1,0), lin(0,-1,2), z);
                    D_DXI2:    t = tm(1'b0, 1, NF_ONE, lin(1,0,-1), z, z);
                    D_DETA2:   t = tm(1'b0, 1, NF_ONE, lin(1,1,0), z, z);
                    D_DXIDETA: t = tm(1'b0, 2, NF_ONE, lin(-1,-2,2), z, z);
                    default: ;
                endcase
            end
            3'd2: begin
                case (d)
                    D_VAL:     t = tm(1'b1, 2, NF_THREE, lin(1,1,0), lin(1,0,1), lin(1,-1,-1));
                    D_DXI:     t = tm(1'b0, 2, NF_TWO, lin(1,0,1), lin(0,2,1), z);
                    D_DETA:    t = tm(1'b0, 2, NF_TWO, lin(1,1,0), lin(0,1,2), z);
                    D_DXI2:    t = tm(1'b0, 1, NF_ONE, lin(1,0,1), z, z);
                    D_DETA2:   t = tm(1'b0, 1, NF_ONE, lin(1,1,0), z, z);
                    D_DXIDETA: t = tm(1'b0, 2, NF_ONE, lin(1,2,2), z, z);
                    default: ;
                endcase
            end
            3'd3: begin
                case (d)
                    D_VAL:     t = tm(1'b1, 2, NF_THREE, lin(1,-1,0), lin(1,0,1), lin(1,1,-1));
                    D_DXI:     t = tm(1'b1, 2, NF_TWO, lin(1,0,1), lin(0,-2,1), z);
                    D_DETA:    t = tm(1'b1, 2, NF_TWO, lin(-1,1,0), lin(0,-1,2), z);
                    D_DXI2:    t = tm(1'b0, 1, NF_ONE, lin(1,0,1), z, z);
                    D_DETA2:   t = tm(1'b0, 1, NF_ONE, lin(1,-1,0), z, z);
                    D_DXIDETA: t = tm(1'b0, 2, NF_ONE, lin(-1,2,-2), z, z);
                    default: ;
                endcase
            end
            3'd4: begin
                case (d)
                    D_VAL:     t = tm(1'b0, 1, NF_THREE, lin(1,-1,0), lin(1,1,0), lin(1,0,-1));
                    D_DXI:     t = tm(1'b0, 0, NF_TWO, lin(0,1,0), lin(-1,0,1), z);
                    D_DETA:    t = tm(1'b0, 1, NF_TWO, lin(1,1,0), lin(-1,1,0), z);
                    D_DXI2:    t = tm(1'b0, 0, NF_ONE, lin(-1,0,1), z, z);
                    D_DXIDETA: t = tm(1'b0, 0, NF_ONE, lin(0,1,0), z, z);
                    default: ;
                endcase
            end
            3'd5: begin
                case (d)
                    D_VAL:     t = tm(1'b0, 1, NF_THREE, lin(1,1,0), lin(1,0,1), lin(1,0,-1));
                    D_DXI:     t = tm(1'b1, 1, NF_TWO, lin(1,0,1), lin(-1,0,1), z);
                    D_DETA:    t = tm(1'b1, 0, NF_TWO, lin(0,0,1), lin(1,1,0), z);
                    D_DETA2:   t = tm(1'b1, 0, NF_ONE, lin(1,1,0), z, z);
                    D_DXIDETA: t = tm(1'b1, 0, NF_ONE, lin(0,0,1), z, z);
                    default: ;
                endcase
            end
            3'd6: begin
                case (d)
                    D_VAL:     t = tm(1'b0, 1, NF_THREE, lin(1,-1,0), lin(1,1,0), lin(1,0,1));
                    D_DXI:     t = tm(1'b1, 0, NF_TWO, lin(0,1,0), lin(1,0,1), z);
                    D_DETA:    t = tm(1'b1, 1, NF_TWO, lin(1,1,0), lin(-1,1,0), z);
                    D_DXI2:    t = tm(1'b1, 0, NF_ONE, lin(1,0,1), z, z);
                    D_DXIDETA: t = tm(1'b1, 0, NF_ONE, lin(0,1,0), z, z);
                    default: ;
                endcase
            end
            3'd7: begin
                case (d)
                    D_VAL:     t = tm(1'b0, 1, NF_THREE, lin(1,-1,0), lin(1,0,1), lin(1,0,-1));
                    D_DXI:     t = tm(1'b0, 1, NF_TWO, lin(1,0,1), lin(-1,0,1), z);
                    D_DETA:    t = tm(1'b0, 0, NF_TWO, lin(0,0,1), lin(-1,1,0), z);
                    D_DETA2:   t = tm(1'b0, 0, NF_ONE, lin(-1,1,0), z, z);
                    D_DXIDETA: t = tm(1'b0, 0, NF_ONE, lin(0,0,1), z, z);
                    default: ;
                endcase
            end
            default: ;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/sq8_factor_gen.sv =====
// Front end of the shape evaluator: term decode and linear factor formation.
// Depends on sq8_pkg.
module sq8_factor_gen
    import sq8_pkg::*;
(
    input  logic signed [COORD_W-1:0] i_xi,
    input  logic signed [COORD_W-1:0] i_eta,
    input  logic [3:0]                i_basis_index,
    input  logic [2:0]                i_derivative_select,
    output t_ctl                      o_ctl,
    output logic signed [FACT_W-1:0]  o_fa,
    output logic signed [FACT_W-1:0]  o_fb,
    output logic signed [FACT_W-1:0]  o_fc
);

    localparam logic signed [FACT_W-1:0] ONE = FACT_W'(1) << COORD_FRAC_BITS;

    function automatic logic signed [FACT_W-1:0] scale(input logic signed [2:0] k,
                                                        input logic signed [COORD_W-1:0] v);
        logic signed [FACT_W-1:0] e;
        logic signed [FACT_W-1:0] r;
        e = FACT_W'(v);
        case (k)
            3'sb001: r = e;
            3'sb010: r = e <<< 1;
            3'sb111: r = -e;
            3'sb110: r = -(e <<< 1);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [FACT_W-1:0] lin_eval(input t_lin l,
                                                           input logic signed [COORD_W-1:0] x,
                                                           input logic signed [COORD_W-1:0] y);
        logic signed [FACT_W-1:0] c;
        case (l.k0)
            2'sb01:  c = ONE;
            2'sb11:  c = -ONE;
            default: c = '0;
        endcase
        return c + scale(l.kx, x) + scale(l.ky, y);
    endfunction

    t_term w_term;

    always_comb begin
        w_term     = decode(i_basis_index[2:0], i_derivative_select);
        o_ctl.zero = w_term.zero;
        o_ctl.inv  = i_basis_index[3];
        o_ctl.neg  = w_term.neg;
        o_ctl.cs   = w_term.cs;
        o_ctl.nf   = w_term.nf;
        o_fa       = lin_eval(w_term.fa, i_xi, i_eta);
        o_fb       = lin_eval(w_term.fb, i_xi, i_eta);
        o_fc       = lin_eval(w_term.fc, i_xi, i_eta);
    end

endmodule

// ===== rtl/serendipity_quad8_shape_eval.sv =====
// Top level of the eight-node serendipity quadrilateral shape evaluator.
// Depends on sq8_pkg and sq8_factor_gen.
//
// Takes one evaluation point per cycle unless back-pressure holds the input, and returns one
// result per point, in order, from the last stage. The pipeline has five
// register stages: factor formation, first product, intermediate rounding, second
// product, and final sign, rounding and saturation into the output register. Each
// stage holds its item while the stage after it is full and stalled, so back-pressure stops the
// input only once every stage is occupied. A basis index above 7 gives a zero value
// with the invalid flag set; derivative codes 6 and 7 give zero.
module serendipity_quad8_shape_eval
    import sq8_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // xi[15:0], eta[31:16]
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,  // basis_index[3:0], derivative_select[6:4]
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // basis_value[17:0], zero pad above
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser   // invalid_basis[0]
);

    localparam logic signed [PROD_W-1:0] HALF_F = PROD_W'(1) << (COORD_FRAC_BITS - 1);

    t_ctl                     n_s1_ctl;
    logic signed [FACT_W-1:0] n_s1_a, n_s1_b, n_s1_c;

    logic                     r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;
    logic                     w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    t_ctl                     r_s1_ctl, r_s2_ctl, r_s3_ctl, r_s4_ctl;
    logic signed [FACT_W-1:0] r_s1_a, r_s1_b, r_s1_c;
    logic signed [FACT_W-1:0] r_s2_a, r_s2_c, r_s3_a, r_s3_c;
    logic signed [PROD_W-1:0] r_s2_p, r_s3_p;
    logic signed [RND_W-1:0]  r_s3_q;
    logic signed [VAL_W-1:0]  r_s4_val;
    logic signed [OUT_W-1:0]  r_s5_value;
    logic                     r_s5_inv;

    logic signed [PROD_W-1:0]       n_s2_p;
    logic signed [PROD_W-1:0]       w_s3_sum;
    logic signed [RND_W-1:0]        n_s3_q;
    logic signed [RND_W+FACT_W-1:0] w_s4_prod;
    logic signed [VAL_W-1:0]        n_s4_val;
    logic [SH_W-1:0]                w_s5_sh;
    logic signed [VAL_W-1:0]        w_s5_v, w_s5_half, w_s5_adj, w_s5_rnd;
    logic signed [OUT_W-1:0]        n_s5_value;

    sq8_factor_gen u_factor_gen (
        .i_xi                (i_s_axis_tdata[COORD_W-1:0]),
        .i_eta               (i_s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_basis_index       (i_s_axis_tuser[3:0]),
        .i_derivative_select (i_s_axis_tuser[6:4]),
        .o_ctl               (n_s1_ctl),
        .o_fa                (n_s1_a),
        .o_fb                (n_s1_b),
        .o_fc                (n_s1_c)
    );

    assign w_rdy5          = !r_s5_v || i_m_axis_tready;
    assign w_rdy4          = !r_s4_v || w_rdy5;
    assign w_rdy3          = !r_s3_v || w_rdy4;
    assign w_rdy2          = !r_s2_v || w_rdy3;
    assign w_rdy1          = !r_s1_v || w_rdy2;
    assign o_s_axis_tready = w_rdy1;

    assign n_s2_p   = r_s1_a * r_s1_b;
    assign w_s3_sum = r_s2_p + ((r_s2_p < 0) ? (HALF_F - PROD_W'(1)) : HALF_F);
    assign n_s3_q   = RND_W'(w_s3_sum >>> COORD_FRAC_BITS);
    assign w_s4_prod = r_s3_q * r_s3_c;

    always_comb begin
        case (r_s3_ctl.nf)
            NF_ONE:   n_s4_val = VAL_W'(r_s3_a);
            NF_TWO:   n_s4_val = VAL_W'(r_s3_p);
            NF_THREE: n_s4_val = VAL_W'(w_s4_prod);
            default:  n_s4_val = '0;
        endcase
    end

    always_comb begin
        w_s5_v  = r_s4_ctl.neg ? -r_s4_val : r_s4_val;
        w_s5_sh = (r_s4_ctl.nf == NF_ONE) ? SH_W'(r_s4_ctl.cs)
                                          : SH_W'(COORD_FRAC_BITS) + SH_W'(r_s4_ctl.cs);
        if (w_s5_sh == '0) begin
            w_s5_half = '0;
            w_s5_adj  = '0;
        end else begin
            w_s5_half = VAL_W'(1) << (w_s5_sh - SH_W'(1));
            w_s5_adj  = (w_s5_v < 0) ? (w_s5_half - VAL_W'(1)) : w_s5_half;
        end
        w_s5_rnd = (w_s5_v + w_s5_adj) >>> w_s5_sh;
        if (r_s4_ctl.zero || r_s4_ctl.inv) begin
            n_s5_value = '0;
        end else if (w_s5_rnd > VAL_W'(OUT_MAX)) begin
            n_s5_value = OUT_MAX;
        end else if (w_s5_rnd < VAL_W'(OUT_MIN)) begin
            n_s5_value = OUT_MIN;
        end else begin
            n_s5_value = OUT_W'(w_s5_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else begin
            if (w_rdy1) r_s1_v <= i_s_axis_tvalid;
            if (w_rdy2) r_s2_v <= r_s1_v;
            if (w_rdy3) r_s3_v <= r_s2_v;
            if (w_rdy4) r_s4_v <= r_s3_v;
            if (w_rdy5) r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_s_axis_tvalid) begin
            r_s1_ctl <= n_s1_ctl;
            r_s1_a   <= n_s1_a;
            r_s1_b   <= n_s1_b;
            r_s1_c   <= n_s1_c;
        end
        if (w_rdy2 && r_s1_v) begin
            r_s2_ctl <= r_s1_ctl;
            r_s2_a   <= r_s1_a;
            r_s2_p   <= n_s2_p;
            r_s2_c   <= r_s1_c;
        end
        if (w_rdy3 && r_s2_v) begin
            r_s3_ctl <= r_s2_ctl;
            r_s3_a   <= r_s2_a;
            r_s3_p   <= r_s2_p;
            r_s3_q   <= n_s3_q;
            r_s3_c   <= r_s2_c;
        end
        if (w_rdy4 && r_s3_v) begin
            r_s4_ctl <= r_s3_ctl;
            r_s4_val <= n_s4_val;
        end
        if (w_rdy5 && r_s4_v) begin
            r_s5_value <= n_s5_value;
            r_s5_inv   <= r_s4_ctl.inv;
        end
    end

    assign o_m_axis_tvalid = r_s5_v;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, r_s5_value};
    assign o_m_axis_tuser  = r_s5_inv;

endmodule

// ===== rtl/sq8_chk.sv =====
// Port-level checker for the serendipity shape evaluator, bound to the top level.
// Depends on sq8_pkg and serendipity_quad8_shape_eval.
module sq8_chk
    import sq8_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tready,
    input logic                   i_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] i_m_tdata,
    input logic [OUT_TUSER_W-1:0] i_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("output request changed while stalled");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[0] |-> i_m_tdata == '0)
        else $error("invalid basis with nonzero value");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_tvalid |-> i_s_tready)
        else $error("input stalled with empty output");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[OUT_TDATA_W-1:OUT_W] == '0)
        else $error("pad bits of output data not zero");

endmodule

bind serendipity_quad8_shape_eval sq8_chk u_sq8_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

// ===== bench/serendipity_quad8_shape_eval_tb.sv =====
// Self-checking testbench for serendipity_quad8_shape_eval, the eight-node quad shape evaluator.
// Drives a directed table, then random points with random gaps and back-pressure on both streams,
// and checks each result by table value or fixed-point predictor. Depends on sq8_pkg and the RTL.
module serendipity_quad8_shape_eval_tb
    import sq8_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DIRECTED = 25;
    localparam int NUM_RANDOM   = 700;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_AT     = 200;
    localparam int STALL_CYCLES = 80;
    localparam int CALM_FROM    = 400;
    localparam int CALM_TO      = 520;
    localparam int IDLE_PCT     = 28;

    localparam logic [2:0] DSEL_UNUSED6 = 3'd6;
    localparam logic [2:0] DSEL_UNUSED7 = 3'd7;

    localparam logic signed [COORD_W-1:0] C_ZERO = 16'sd0;
    localparam logic signed [COORD_W-1:0] C_ONE  = 16'sd16384;
    localparam logic signed [COORD_W-1:0] C_MONE = -16'sd16384;
    localparam logic signed [COORD_W-1:0] C_MAX  = 16'sd32767;
    localparam logic signed [COORD_W-1:0] C_MIN  = -16'sd32768;

    typedef struct packed {
        logic signed [COORD_W-1:0] xi;
        logic signed [COORD_W-1:0] eta;
        logic [3:0]                node;
        logic [2:0]                dsel;
    } t_point;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             invalid;
    } t_result;

    typedef struct packed {
        logic             known;
        logic [OUT_W-1:0] value;
        logic             invalid;
    } t_note;

    typedef struct packed {
        t_point pt;
        t_note  note;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;  // xi[15:0], eta[31:16]
    logic [IN_TUSER_W-1:0]  i_s_axis_tuser = '0;  // basis_index[3:0], derivative_select[6:4]
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;       // basis_value[17:0], zero pad above
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;       // invalid_basis[0]

    t_result pending_results[$];
    t_note   row_notes[$];
    int      fail_count = 0;
    int      sent_count = 0;
    int      cycle_count = 0;
    logic    calm;

    t_row directed_rows [NUM_DIRECTED] = '{
        '{'{C_MONE, C_MONE, 4'd0, D_VAL},        '{1'b1, 18'd16384, 1'b0}},
        '{'{C_ONE,  C_MONE, 4'd1, D_VAL},        '{1'b1, 18'd16384, 1'b0}},
        '{'{C_ONE,  C_ONE,  4'd2, D_VAL},        '{1'b1, 18'd16384, 1'b0}},
        '{'{C_ZERO, C_MONE, 4'd4, D_VAL},        '{1'b1, 18'd16384, 1'b0}},
        '{'{C_ZERO, C_ZERO, 4'd0, DSEL_UNUSED6}, '{1'b1, 18'd0, 1'b0}},
        '{'{C_MAX,  C_MIN,  4'd7, DSEL_UNUSED7}, '{1'b1, 18'd0, 1'b0}},
        '{'{C_ZERO, C_ZERO, 4'd8, D_VAL},        '{1'b1, 18'd0, 1'b1}},
        '{'{C_MIN,  C_MAX,  4'd15, D_DXIDETA},   '{1'b1, 18'd0, 1'b1}},
        '{'{C_MAX,  C_MAX,  4'd4, D_DETA2},      '{1'b1, 18'd0, 1'b0}},
        '{'{C_MIN,  C_MIN,  4'd5, D_DXI2},       '{1'b1, 18'd0, 1'b0}},
        '{'{C_MAX,  C_MIN,  4'd6, D_DETA2},      '{1'b1, 18'd0, 1'b0}},
        '{'{C_MIN,  C_MAX,  4'd7, D_DXI2},       '{1'b1, 18'd0, 1'b0}},
        '{'{C_MIN,  C_MIN,  4'd0, D_VAL},        '{1'b0, 18'd0, 1'b0}},
        '{'{C_MAX,  C_MAX,  4'd2, D_VAL},        '{1'b0, 18'd0, 1'b0}},
        '{'{C_MIN,  C_MAX,  4'd3, D_DXI},        '{1'b0, 18'd0, 1'b0}},
        '{'{C_MAX,  C_MIN,  4'd1, D_DETA},       '{1'b0, 18'd0, 1'b0}},
        '{'{C_MIN,  C_MIN,  4'd4, D_DXI},        '{1'b0, 18'd0, 1'b0}},
        '{'{C_MAX,  C_MIN,  4'd5, D_DXIDETA},    '{1'b0, 18'd0, 1'b0}},
        '{'{C_MIN,  C_MAX,  4'd6, D_DXI2},       '{1'b0, 18'd0, 1'b0}},
        '{'{C_MAX,  C_MAX,  4'd7, D_DETA2},      '{1'b0, 18'd0, 1'b0}},
        '{'{C_MIN,  C_MIN,  4'd2, D_DXIDETA},    '{1'b0, 18'd0, 1'b0}},
        '{'{C_MAX,  C_MIN,  4'd3, D_DXI2},       '{1'b0, 18'd0, 1'b0}},
        '{'{C_MIN,  C_MAX,  4'd1, D_DETA2},      '{1'b0, 18'd0, 1'b0}},
        '{'{16'sh2AAA, -16'sh1555, 4'd0, D_DETA}, '{1'b0, 18'd0, 1'b0}},
        '{'{C_MAX,  C_MIN,  4'd6, D_VAL},        '{1'b0, 18'd0, 1'b0}}
    };

    serendipity_quad8_shape_eval DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    assign calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);

    function automatic longint round_half_away(input longint v, input int s);
        longint m;
        if (s == 0)
            return v;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint scaled_product(input bit neg, input int cs, input int nf,
                                              input longint a, input longint b,
                                              input longint c);
        longint p;
        int     s;
        if (nf == 1) begin
            p = a;
            s = cs;
        end else if (nf == 2) begin
            p = a * b;
            s = COORD_FRAC_BITS + cs;
        end else begin
            p = round_half_away(a * b, COORD_FRAC_BITS) * c;
            s = COORD_FRAC_BITS + cs;
        end
        if (neg)
            p = -p;
        return round_half_away(p, s);
    endfunction

    function automatic t_result predict_shape(input t_point pt);
        longint  x;
        longint  y;
        longint  one;
        longint  v;
        t_result r;
        x   = longint'(pt.xi);
        y   = longint'(pt.eta);
        one = 64'sd1 <<< COORD_FRAC_BITS;
        v   = 0;
        r.invalid = (pt.node > 4'd7);
        if (!r.invalid) begin
            case (pt.node[2:0])
                3'd0: begin
                    case (pt.dsel)
                        D_VAL:     v = scaled_product(1, 2, 3, one - x, one - y, one + x + y);
                        D_DXI:     v = scaled_product(1, 2, 2, y - one, 2 * x + y, 0);
                        D_DETA:    v = scaled_product(1, 2, 2, x - one, x + 2 * y, 0);
                        D_DXI2:    v = scaled_product(0, 1, 1, one - y, 0, 0);
                        D_DETA2:   v = scaled_product(0, 1, 1, one - x, 0, 0);
                        D_DXIDETA: v = scaled_product(0, 2, 1, one - 2 * x - 2 * y, 0, 0);
                        default: ;
                    endcase
                end
                3'd1: begin
                    case (pt.dsel)
                        D_VAL:     v = scaled_product(1, 2, 3, one + x, one - y, one - x + y);
                        D_DXI:     v = scaled_product(0, 2, 2, y - one, y - 2 * x, 0);
                        D_DETA:    v = scaled_product(0, 2, 2, one + x, 2 * y - x, 0);
                        D_DXI2:    v = scaled_product(0, 1, 1, one - y, 0, 0);
                        D_DETA2:   v = scaled_product(0, 1, 1, one + x, 0, 0);
                        D_DXIDETA: v = scaled_product(0, 2, 1, 2 * y - 2 * x - one, 0, 0);
                        default: ;
                    endcase
                end
                3'd2: begin
                    case (pt.dsel)
                        D_VAL:     v = scaled_product(1, 2, 3, one + x, one + y, one - x - y);
                        D_DXI:     v = scaled_product(0, 2, 2, one + y, 2 * x + y, 0);
                        D_DETA:    v = scaled_product(0, 2, 2, one + x, x + 2 * y, 0);
                        D_DXI2:    v = scaled_product(0, 1, 1, one + y, 0, 0);
                        D_DETA2:   v = scaled_product(0, 1, 1, one + x, 0, 0);
                        D_DXIDETA: v = scaled_product(0, 2, 1, one + 2 * x + 2 * y, 0, 0);
                        default: ;
                    endcase
                end
                3'd3: begin
                    case (pt.dsel)
                        D_VAL:     v = scaled_product(1, 2, 3, one - x, one + y, one + x - y);
                        D_DXI:     v = scaled_product(1, 2, 2, one + y, y - 2 * x, 0);
                        D_DETA:    v = scaled_product(1, 2, 2, x - one, 2 * y - x, 0);
                        D_DXI2:    v = scaled_product(0, 1, 1, one + y, 0, 0);
                        D_DETA2:   v = scaled_product(0, 1, 1, one - x, 0, 0);
                        D_DXIDETA: v = scaled_product(0, 2, 1, 2 * x - 2 * y - one, 0, 0);
                        default: ;
                    endcase
                end
                3'd4: begin
                    case (pt.dsel)
                        D_VAL:     v = scaled_product(0, 1, 3, one - x, one + x, one - y);
                        D_DXI:     v = scaled_product(0, 0, 2, x, y - one, 0);
                        D_DETA:    v = scaled_product(0, 1, 2, one + x, x - one, 0);
                        D_DXI2:    v = scaled_product(0, 0, 1, y - one, 0, 0);
                        D_DXIDETA: v = scaled_product(0, 0, 1, x, 0, 0);
                        default: ;
                    endcase
                end
                3'd5: begin
                    case (pt.dsel)
                        D_VAL:     v = scaled_product(0, 1, 3, one + x, one + y, one - y);
                        D_DXI:     v = scaled_product(1, 1, 2, one + y, y - one, 0);
                        D_DETA:    v = scaled_product(1, 0, 2, y, one + x, 0);
                        D_DETA2:   v = scaled_product(1, 0, 1, one + x, 0, 0);
                        D_DXIDETA: v = scaled_product(1, 0, 1, y, 0, 0);
                        default: ;
                    endcase
                end
                3'd6: begin
                    case (pt.dsel)
                        D_VAL:     v = scaled_product(0, 1, 3, one - x, one + x, one + y);
                        D_DXI:     v = scaled_product(1, 0, 2, x, one + y, 0);
                        D_DETA:    v = scaled_product(1, 1, 2, one + x, x - one, 0);
                        D_DXI2:    v = scaled_product(1, 0, 1, one + y, 0, 0);
                        D_DXIDETA: v = scaled_product(1, 0, 1, x, 0, 0);
                        default: ;
                    endcase
                end
                default: begin
                    case (pt.dsel)
                        D_VAL:     v = scaled_product(0, 1, 3, one - x, one + y, one - y);
                        D_DXI:     v = scaled_product(0, 1, 2, one + y, y - one, 0);
                        D_DETA:    v = scaled_product(0, 0, 2, y, x - one, 0);
                        D_DETA2:   v = scaled_product(0, 0, 1, x - one, 0, 0);
                        D_DXIDETA: v = scaled_product(0, 0, 1, y, 0, 0);
                        default: ;
                    endcase
                end
            endcase
        end
        if (v > longint'(OUT_MAX))
            v = longint'(OUT_MAX);
        if (v < longint'(OUT_MIN))
            v = longint'(OUT_MIN);
        r.value = v[OUT_W-1:0];
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return $urandom_range(1) ? C_ONE : C_MONE;
            3, 4:    return COORD_W'($urandom);
            default: return COORD_W'(int'($urandom_range(32768)) - 16384);
        endcase
    endfunction

    task automatic offer_point(input t_point p, input t_note note);
        row_notes.push_back(note);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {p.eta, p.xi};
        i_s_axis_tuser  <= {p.dsel, p.node};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        sent_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_point  pt;
        t_note   note;
        t_result want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                pt.xi   = i_s_axis_tdata[15:0];
                pt.eta  = i_s_axis_tdata[31:16];
                pt.node = i_s_axis_tuser[3:0];
                pt.dsel = i_s_axis_tuser[6:4];
                want = predict_shape(pt);
                if (row_notes.size() != 0) begin
                    note = row_notes.pop_front();
                    if (note.known) begin
                        want.value   = note.value;
                        want.invalid = note.invalid;
                    end
                end
                pending_results.push_back(want);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result value %h invalid %b", $time,
                             o_m_axis_tdata[OUT_W-1:0], o_m_axis_tuser[0]);
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_axis_tdata[OUT_W-1:0] !== want.value) begin
                        fail_count++;
                        $display("%0t: basis_value expected %h actual %h", $time,
                                 want.value, o_m_axis_tdata[OUT_W-1:0]);
                    end
                    if (o_m_axis_tuser[0] !== want.invalid) begin
                        fail_count++;
                        $display("%0t: invalid_basis expected %b actual %b", $time,
                                 want.invalid, o_m_axis_tuser[0]);
                    end
                end
            end
        end
    end

    initial begin
        int stall_left;
        bit stall_done;
        stall_left = 0;
        stall_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!stall_done && sent_count >= STALL_AT) begin
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("serendipity_quad8_shape_eval regression: fail");
        $finish;
    end

    initial begin
        int     k;
        t_point p;
        t_note  blank;
        blank = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (k = 0; k < NUM_DIRECTED; k++)
            offer_point(directed_rows[k].pt, directed_rows[k].note);
        for (k = 0; k < NUM_RANDOM; k++) begin
            p.xi   = rand_coord();
            p.eta  = rand_coord();
            p.node = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 8)) : 4'($urandom_range(7));
            p.dsel = 3'($urandom_range(7));
            offer_point(p, blank);
        end
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("serendipity_quad8_shape_eval regression: pass");
        end else begin
            $display("serendipity_quad8_shape_eval regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sq8_pkg.sv
rtl/sq8_factor_gen.sv
rtl/serendipity_quad8_shape_eval.sv
rtl/sq8_chk.sv
bench/serendipity_quad8_shape_eval_tb.sv
